// File: design/sn2o_pkg.sv
package sn2o_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int MAX_OCTAVES = 8;
    localparam int MUL_A_W     = 41;
    localparam int MUL_B_W     = 26;
    localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
    localparam int DW          = 19;

    localparam logic [15:0] SKEW_Q   = 16'd23988;
    localparam logic [15:0] UNSKEW_Q = 16'd13849;
    localparam logic [21:0] AMP_Q16  = 22'd2964236;
    localparam logic [16:0] FX_ONE   = 17'd65536;
    localparam logic [19:0] FX_HALF  = 20'd32768;

    localparam logic [7:0] CFG_BASE_SCALE   = 8'd0;
    localparam logic [7:0] CFG_OCTAVE_COUNT = 8'd1;

    localparam logic OP_EVAL  = 1'b0;
    localparam logic OP_LOAD  = 1'b1;

    typedef logic signed [MUL_A_W-1:0] mul_a_t;
    typedef logic signed [MUL_B_W-1:0] mul_b_t;
    typedef logic signed [MUL_P_W-1:0] mul_p_t;

    function automatic logic [16:0] recip_q16(input logic [3:0] n);
        logic [16:0] r;
        case (n)
            4'd1:    r = 17'd65536;
            4'd2:    r = 17'd43691;
            4'd3:    r = 17'd37449;
            4'd4:    r = 17'd34953;
            4'd5:    r = 17'd33825;
            4'd6:    r = 17'd33288;
            4'd7:    r = 17'd33026;
            4'd8:    r = 17'd32897;
            default: r = 17'd65536;
        endcase
        return r;
    endfunction

endpackage

// File: design/simplex_noise_2d_octaves_core.sv
// Fractal 2D simplex noise. An evaluate word runs octave_count octaves, clamped to 1..8,
// one after another, and in_ready stays low from its accept to the next accept. A result
// still waiting at the output holds the last step until it is taken. The pace is set by
// the one shared 41x26 multiplier, used for every product in turn, and by the single read
// port of the 256-entry permutation table. A load word writes one table entry in its
// accept cycle and gives no output. The table has no reset: load every entry that an
// evaluation may touch first. Configuration writes are always ready.
module simplex_noise_2d_octaves_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               op,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_y,
    input  logic [7:0]         perm_index,
    input  logic [7:0]         perm_value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] noise_value,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_index,
    input  logic [23:0]        cfg_data
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_MX   = 5'd1;
    localparam logic [4:0] S_MY   = 5'd2;
    localparam logic [4:0] S_Y    = 5'd3;
    localparam logic [4:0] S_SK   = 5'd4;
    localparam logic [4:0] S_XS   = 5'd5;
    localparam logic [4:0] S_UT   = 5'd6;
    localparam logic [4:0] S_OFF  = 5'd7;
    localparam logic [4:0] S_R1   = 5'd8;
    localparam logic [4:0] S_R2   = 5'd9;
    localparam logic [4:0] S_R3   = 5'd10;
    localparam logic [4:0] S_R4   = 5'd11;
    localparam logic [4:0] S_R5   = 5'd12;
    localparam logic [4:0] S_R6   = 5'd13;
    localparam logic [4:0] S_C0   = 5'd14;
    localparam logic [4:0] S_C1   = 5'd15;
    localparam logic [4:0] S_C2   = 5'd16;
    localparam logic [4:0] S_C3   = 5'd17;
    localparam logic [4:0] S_C4   = 5'd18;
    localparam logic [4:0] S_C5   = 5'd19;
    localparam logic [4:0] S_F0   = 5'd20;
    localparam logic [4:0] S_F1   = 5'd21;
    localparam logic [4:0] S_F2   = 5'd22;
    localparam logic [4:0] S_F3   = 5'd23;

    localparam int DW = sn2o_pkg::DW;

    logic [4:0]  state_reg, state_next;
    logic [23:0] base_scale_reg;
    logic [3:0]  octave_count_reg;
    logic [3:0]  n_reg;
    logic [2:0]  k_reg;
    logic [1:0]  cidx_reg;
    logic signed [31:0] cx_reg, cy_reg;
    logic [39:0] xs_reg, ys_reg;
    logic [7:0]  ci_reg, cj_reg;
    logic [15:0] fx_reg, fy_reg;
    logic signed [DW-1:0] x0_reg, y0_reg;
    logic        i1_reg;
    logic [7:0]  p0_reg, p1_reg, p2_reg;
    logic [7:0]  h0_reg, h1_reg, h2_reg;
    logic [17:0] sqx_reg;
    logic signed [39:0] sum_reg;
    logic signed [31:0] acc_reg;
    logic        out_valid_reg;
    logic signed [15:0] noise_reg;

    sn2o_pkg::mul_a_t ma;
    sn2o_pkg::mul_b_t mb;
    sn2o_pkg::mul_p_t prod;
    sn2o_pkg::mul_p_t prod_k;
    logic [7:0]  raddr, rdata;
    logic        in_acc, ram_we;
    logic [3:0]  n_clamp;
    logic [23:0] skew, xs24, ys24;
    logic signed [DW-1:0] x0_new, y0_new, x1, y1, x2, y2, dx, dy, u, v;
    logic [7:0]  hsel;
    logic signed [21:0] gr;
    logic signed [19:0] tval;
    logic        last_oct, last_corner, out_free;
    logic signed [23:0] sq;
    logic signed [31:0] oct;
    logic signed [31:0] oct_w;
    logic [2:0]  wshift;
    logic signed [sn2o_pkg::MUL_P_W-1:0] res;
    logic signed [15:0] res_sat;

    sn2o_mul u_mul
    (
        .clk  (clk),
        .a    (ma),
        .b    (mb),
        .prod (prod)
    );

    sn2o_perm_ram u_ram
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (perm_index),
        .wdata (perm_value),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign in_ready    = (state_reg == S_IDLE);
    assign in_acc      = in_valid && in_ready;
    assign ram_we      = in_acc && (op == sn2o_pkg::OP_LOAD);
    assign cfg_ready   = 1'b1;
    assign out_valid   = out_valid_reg;
    assign noise_value = noise_reg;
    assign out_free    = !out_valid_reg || out_ready;

    assign n_clamp = (octave_count_reg == 4'd0) ? 4'd1 :
                     (octave_count_reg > 4'(sn2o_pkg::MAX_OCTAVES)) ?
                     4'(sn2o_pkg::MAX_OCTAVES) : octave_count_reg;

    assign prod_k  = prod <<< k_reg;
    assign skew    = prod[39:16];
    assign xs24    = xs_reg[23:0] + skew;
    assign ys24    = ys_reg[23:0] + skew;
    assign x0_new  = DW'($signed({1'b0, fx_reg})) - DW'($signed({1'b0, prod[31:16]}));
    assign y0_new  = DW'($signed({1'b0, fy_reg})) - DW'($signed({1'b0, prod[31:16]}));

    assign x1 = x0_reg - (i1_reg ? DW'(sn2o_pkg::FX_ONE) : DW'(0))
                + DW'(sn2o_pkg::UNSKEW_Q);
    assign y1 = y0_reg - (i1_reg ? DW'(0) : DW'(sn2o_pkg::FX_ONE))
                + DW'(sn2o_pkg::UNSKEW_Q);
    assign x2 = x0_reg - DW'(sn2o_pkg::FX_ONE) + DW'({sn2o_pkg::UNSKEW_Q, 1'b0});
    assign y2 = y0_reg - DW'(sn2o_pkg::FX_ONE) + DW'({sn2o_pkg::UNSKEW_Q, 1'b0});

    always_comb
    begin
        case (cidx_reg)
            2'd0:    begin dx = x0_reg; dy = y0_reg; hsel = h0_reg; end
            2'd1:    begin dx = x1;     dy = y1;     hsel = h1_reg; end
            default: begin dx = x2;     dy = y2;     hsel = h2_reg; end
        endcase
    end

    assign u  = hsel[2] ? dy : dx;
    assign v  = hsel[2] ? dx : dy;
    assign gr = (hsel[0] ? -22'(u) : 22'(u)) + (hsel[1] ? -(22'(v) <<< 1) : (22'(v) <<< 1));

    assign tval = $signed(sn2o_pkg::FX_HALF) - 20'($signed({2'b0, sqx_reg}))
                  - 20'($signed({2'b0, prod[33:16]}));

    assign last_oct    = ({1'b0, k_reg} + 4'd1 == n_reg);
    assign last_corner = (cidx_reg == 2'd2);

    assign sq     = sum_reg[39:16];
    assign oct    = prod[48:17];
    assign wshift = 3'(n_reg - 4'd1 - {1'b0, k_reg});
    assign oct_w  = oct <<< wshift;
    assign res    = prod >>> (5'd15 + {1'b0, n_reg});
    assign res_sat = (res > 67'sd32767) ? 16'sh7FFF :
                     (res < -67'sd32768) ? -16'sh8000 : 16'(res);

    always_comb
    begin
        ma    = '0;
        mb    = '0;
        raddr = cj_reg;
        case (state_reg)
            S_MX:
            begin
                ma = 41'(cx_reg);
                mb = 26'({2'b0, base_scale_reg});
            end
            S_MY:
            begin
                ma = 41'(cy_reg);
                mb = 26'({2'b0, base_scale_reg});
            end
            S_SK:
            begin
                ma = $signed({1'b0, xs_reg + ys_reg});
                mb = 26'(sn2o_pkg::SKEW_Q);
            end
            S_UT:
            begin
                ma = 41'({1'b0, fx_reg} + {1'b0, fy_reg});
                mb = 26'(sn2o_pkg::UNSKEW_Q);
            end
            S_OFF: raddr = cj_reg;
            S_R1:  raddr = cj_reg + 8'(!i1_reg);
            S_R2:  raddr = cj_reg + 8'd1;
            S_R3:  raddr = ci_reg + p0_reg;
            S_R4:  raddr = ci_reg + 8'(i1_reg) + p1_reg;
            S_R5:  raddr = ci_reg + 8'd1 + p2_reg;
            S_C0:
            begin
                ma = 41'(dx);
                mb = 26'(dx);
            end
            S_C1:
            begin
                ma = 41'(dy);
                mb = 26'(dy);
            end
            S_C2:
            begin
                ma = 41'(tval);
                mb = 26'(tval);
            end
            S_C3:
            begin
                ma = 41'({1'b0, prod[31:16]});
                mb = 26'({1'b0, prod[31:16]});
            end
            S_C4:
            begin
                ma = 41'({1'b0, prod[31:16]});
                mb = 26'(gr);
            end
            S_F0:
            begin
                ma = 41'(sq);
                mb = 26'(sn2o_pkg::AMP_Q16);
            end
            S_F2, S_F3:
            begin
                ma = 41'(acc_reg);
                mb = 26'(sn2o_pkg::recip_q16(n_reg));
            end
            default:
            begin
                ma = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (in_acc && op == sn2o_pkg::OP_EVAL) state_next = S_MX;
            S_MX:   state_next = S_MY;
            S_MY:   state_next = S_Y;
            S_Y:    state_next = S_SK;
            S_SK:   state_next = S_XS;
            S_XS:   state_next = S_UT;
            S_UT:   state_next = S_OFF;
            S_OFF:  state_next = S_R1;
            S_R1:   state_next = S_R2;
            S_R2:   state_next = S_R3;
            S_R3:   state_next = S_R4;
            S_R4:   state_next = S_R5;
            S_R5:   state_next = S_R6;
            S_R6:   state_next = S_C0;
            S_C0:   state_next = S_C1;
            S_C1:   state_next = S_C2;
            S_C2:
            begin
                if (tval < 0)
                    state_next = last_corner ? S_F0 : S_C0;
                else
                    state_next = S_C3;
            end
            S_C3:   state_next = S_C4;
            S_C4:   state_next = S_C5;
            S_C5:   state_next = last_corner ? S_F0 : S_C0;
            S_F0:   state_next = S_F1;
            S_F1:   state_next = last_oct ? S_F2 : S_MX;
            S_F2:   state_next = S_F3;
            S_F3:   if (out_free) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            base_scale_reg   <= 24'd65536;
            octave_count_reg <= 4'd1;
            out_valid_reg    <= 1'b0;
            n_reg            <= 4'd1;
            k_reg            <= 3'd0;
            cidx_reg         <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_index == sn2o_pkg::CFG_BASE_SCALE)
                base_scale_reg <= cfg_data;
            if (cfg_valid && cfg_index == sn2o_pkg::CFG_OCTAVE_COUNT)
                octave_count_reg <= cfg_data[3:0];
            if (state_reg == S_F3 && out_free)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (in_acc)
            begin
                n_reg <= n_clamp;
                k_reg <= 3'd0;
            end
            if (state_reg == S_F1 && !last_oct)
                k_reg <= k_reg + 3'd1;
            if (state_reg == S_R6)
                cidx_reg <= 2'd0;
            if ((state_reg == S_C5) || (state_reg == S_C2 && tval < 0))
                cidx_reg <= last_corner ? 2'd0 : cidx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                cx_reg  <= coord_x;
                cy_reg  <= coord_y;
                acc_reg <= '0;
            end
            S_MY: xs_reg <= prod_k[55:16];
            S_Y:  ys_reg <= prod_k[55:16];
            S_XS:
            begin
                ci_reg <= xs24[23:16];
                cj_reg <= ys24[23:16];
                fx_reg <= xs24[15:0];
                fy_reg <= ys24[15:0];
            end
            S_OFF:
            begin
                x0_reg <= x0_new;
                y0_reg <= y0_new;
                i1_reg <= (x0_new > y0_new);
            end
            S_R1: p0_reg <= rdata;
            S_R2: p1_reg <= rdata;
            S_R3: p2_reg <= rdata;
            S_R4: h0_reg <= rdata;
            S_R5: h1_reg <= rdata;
            S_R6:
            begin
                h2_reg  <= rdata;
                sum_reg <= '0;
            end
            S_C1: sqx_reg <= prod[33:16];
            S_C5: sum_reg <= sum_reg + prod[39:0];
            S_F1: acc_reg <= acc_reg + oct_w;
            S_F3: if (out_free) noise_reg <= res_sat;
            default: ;
        endcase
    end

    a_eval_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && op == sn2o_pkg::OP_EVAL) |=> (state_reg == S_MX))
        else $error("evaluate word did not start the sequencer");

    a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && op == sn2o_pkg::OP_LOAD) |=> (state_reg == S_IDLE))
        else $error("load word left idle");

    a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_F3))
        else $error("result appeared outside the final step");

    a_octave_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (({1'b0, k_reg} < n_reg) && (n_reg >= 4'd1)
        && (n_reg <= 4'(sn2o_pkg::MAX_OCTAVES))))
        else $error("octave counter out of range");

endmodule

// File: design/sn2o_mul.sv
module sn2o_mul
(
    input  logic            clk,
    input  sn2o_pkg::mul_a_t a,
    input  sn2o_pkg::mul_b_t b,
    output sn2o_pkg::mul_p_t prod
);

    sn2o_pkg::mul_p_t prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= sn2o_pkg::MUL_P_W'(a) * sn2o_pkg::MUL_P_W'(b);
    end

    assign prod = prod_reg;

endmodule

// File: design/sn2o_perm_ram.sv
module sn2o_perm_ram
(
    input  logic       clk,
    input  logic       we,
    input  logic [7:0] waddr,
    input  logic [7:0] wdata,
    input  logic [7:0] raddr,
    output logic [7:0] rdata
);

    logic [7:0] mem [256];
    logic [7:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
